// File: rtl/core/npdu_pkg.sv
// Shared types and constants for the NPDU header parser.
`timescale 1ns / 1ps

package npdu_pkg;

   localparam int MAX_ADDR_BYTES_DEF = 7;

   localparam int CTL_NETMSG_BIT = 7;
   localparam int CTL_DEST_BIT   = 5;
   localparam int CTL_SRC_BIT    = 3;

   localparam int ADDR_W     = 56;
   localparam int RSP_DATA_W = 176;

   localparam int STATUS_LSB  = 0;
   localparam int CONTROL_LSB = 2;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NETMSG  = 2'd1,
      ST_ADDR_LEN = 2'd2,
      ST_TRUNC   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0]        data_byte;
      logic [7:0]        hops_left;
      logic [ADDR_W-1:0] src_address;
      logic [2:0]        src_length;
      logic [15:0]       src_network;
      logic [ADDR_W-1:0] dest_address;
      logic [2:0]        dest_length;
      logic [15:0]       dest_network;
      logic [7:0]        control_bits;
      status_type        status;
   } rsp_data_type;

endpackage

// File: rtl/core/npdu_header_parser.sv
// NPDU header parser: byte-wide frame in, header record and payload bytes out.
// A result is registered: it appears on rsp_ in the cycle after the request byte that causes it.
// Throughput: one request byte per cycle; the header record comes with the byte that
// completes or fails the header, each payload byte gives one result, other bytes none.
// Input stalls only while a result waits in the output register and rsp_tready is low.
// Reset (synchronous, active high) returns the parser to the version byte, empty output.
`timescale 1ns / 1ps

module npdu_header_parser #(
   parameter int MAX_ADDR_BYTES = npdu_pkg::MAX_ADDR_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // frame_byte
   input  logic                              req_tlast,  // end_of_frame
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, control_bits, dest_network, dest_length, dest_address,
   // src_network, src_length, src_address, hops_left, data_byte
   output logic [npdu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,  // kind
   output logic                              rsp_tlast   // last
);

   localparam int CNT_W = $clog2(MAX_ADDR_BYTES + 1);

   typedef enum logic [3:0] {
      PH_VER,
      PH_CTRL,
      PH_DNET_HI,
      PH_DNET_LO,
      PH_DLEN,
      PH_DADR,
      PH_SNET_HI,
      PH_SNET_LO,
      PH_SLEN,
      PH_SADR,
      PH_HOP,
      PH_PAYLOAD,
      PH_DISCARD,
      PH_DONE
   } phase_type;

   phase_type                    phase_ff, phase_in;
   logic [CNT_W-1:0]             addr_cnt_ff, addr_cnt_in;
   logic [7:0]                   version_ff, version_in;
   logic [7:0]                   control_ff, control_in;
   logic [15:0]                  dnet_ff, dnet_in;
   logic [2:0]                   dlen_ff, dlen_in;
   logic [npdu_pkg::ADDR_W-1:0]  daddr_ff, daddr_in;
   logic [15:0]                  snet_ff, snet_in;
   logic [2:0]                   slen_ff, slen_in;
   logic [npdu_pkg::ADDR_W-1:0]  saddr_ff, saddr_in;
   logic [7:0]                   hop_ff, hop_in;

   logic                         rsp_valid_ff;
   npdu_pkg::rsp_data_type       rsp_data_ff, rsp_data_in;
   logic                         rsp_kind_ff, rsp_kind_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         emit;

   logic                         req_accept;
   logic [7:0]                   b;
   logic                         eof;
   logic                         do_adv;
   logic                         do_fail;
   npdu_pkg::status_type         fail_st;
   phase_type                    adv_ph;
   logic [CNT_W-1:0]             cnt_dec;
   logic                         len_bad;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign eof        = req_tlast;
   assign len_bad    = b > 8'(MAX_ADDR_BYTES);
   assign cnt_dec    = (addr_cnt_ff != '0) ? addr_cnt_ff - CNT_W'(1) : addr_cnt_ff;

   always_comb begin
      phase_in    = phase_ff;
      addr_cnt_in = addr_cnt_ff;
      version_in  = version_ff;
      control_in  = control_ff;
      dnet_in     = dnet_ff;
      dlen_in     = dlen_ff;
      daddr_in    = daddr_ff;
      snet_in     = snet_ff;
      slen_in     = slen_ff;
      saddr_in    = saddr_ff;
      hop_in      = hop_ff;
      do_adv      = 1'b0;
      do_fail     = 1'b0;
      fail_st     = npdu_pkg::ST_OK;
      adv_ph      = PH_VER;
      emit        = 1'b0;
      rsp_kind_in = 1'b0;
      rsp_last_in = eof;

      unique case (phase_ff)
         PH_CTRL: begin
            control_in = b;
            if (b[npdu_pkg::CTL_NETMSG_BIT]) begin
               do_fail = 1'b1;
               fail_st = npdu_pkg::ST_NETMSG;
            end else begin
               do_adv = 1'b1;
               adv_ph = b[npdu_pkg::CTL_DEST_BIT] ? PH_DNET_HI :
                        b[npdu_pkg::CTL_SRC_BIT]  ? PH_SNET_HI : PH_DONE;
            end
         end
         PH_DNET_HI: begin
            dnet_in = {b, 8'd0};
            do_adv  = 1'b1;
            adv_ph  = PH_DNET_LO;
         end
         PH_DNET_LO: begin
            dnet_in = {dnet_ff[15:8], b};
            do_adv  = 1'b1;
            adv_ph  = PH_DLEN;
         end
         PH_DLEN: begin
            if (len_bad) begin
               do_fail = 1'b1;
               fail_st = npdu_pkg::ST_ADDR_LEN;
            end else begin
               dlen_in     = b[2:0];
               addr_cnt_in = b[CNT_W-1:0];
               do_adv      = 1'b1;
               adv_ph      = (b != 8'd0) ? PH_DADR :
                             control_ff[npdu_pkg::CTL_SRC_BIT] ? PH_SNET_HI : PH_HOP;
            end
         end
         PH_DADR: begin
            daddr_in    = {daddr_ff[npdu_pkg::ADDR_W-9:0], b};
            addr_cnt_in = cnt_dec;
            do_adv      = 1'b1;
            adv_ph      = (cnt_dec != '0) ? PH_DADR :
                          control_ff[npdu_pkg::CTL_SRC_BIT] ? PH_SNET_HI : PH_HOP;
         end
         PH_SNET_HI: begin
            snet_in = {b, 8'd0};
            do_adv  = 1'b1;
            adv_ph  = PH_SNET_LO;
         end
         PH_SNET_LO: begin
            snet_in = {snet_ff[15:8], b};
            do_adv  = 1'b1;
            adv_ph  = PH_SLEN;
         end
         PH_SLEN: begin
            if (len_bad) begin
               do_fail = 1'b1;
               fail_st = npdu_pkg::ST_ADDR_LEN;
            end else begin
               slen_in     = b[2:0];
               addr_cnt_in = b[CNT_W-1:0];
               do_adv      = 1'b1;
               adv_ph      = (b != 8'd0) ? PH_SADR :
                             control_ff[npdu_pkg::CTL_DEST_BIT] ? PH_HOP : PH_DONE;
            end
         end
         PH_SADR: begin
            saddr_in    = {saddr_ff[npdu_pkg::ADDR_W-9:0], b};
            addr_cnt_in = cnt_dec;
            do_adv      = 1'b1;
            adv_ph      = (cnt_dec != '0) ? PH_SADR :
                          control_ff[npdu_pkg::CTL_DEST_BIT] ? PH_HOP : PH_DONE;
         end
         PH_HOP: begin
            hop_in = b;
            do_adv = 1'b1;
            adv_ph = PH_DONE;
         end
         PH_PAYLOAD: begin
            emit        = 1'b1;
            rsp_kind_in = 1'b1;
            if (eof) begin
               phase_in = PH_VER;
            end
         end
         PH_DISCARD: begin
            if (eof) begin
               phase_in = PH_VER;
            end
         end
         default: begin
            addr_cnt_in = '0;
            version_in  = b;
            control_in  = 8'd0;
            dnet_in     = 16'd0;
            dlen_in     = 3'd0;
            daddr_in    = '0;
            snet_in     = 16'd0;
            slen_in     = 3'd0;
            saddr_in    = '0;
            hop_in      = 8'hFF;
            if (eof) begin
               do_fail = 1'b1;
               fail_st = npdu_pkg::ST_TRUNC;
            end else begin
               phase_in = PH_CTRL;
            end
         end
      endcase

      if (do_adv) begin
         if (adv_ph == PH_DONE) begin
            emit     = 1'b1;
            phase_in = eof ? PH_VER : PH_PAYLOAD;
         end else if (eof) begin
            do_fail = 1'b1;
            fail_st = npdu_pkg::ST_TRUNC;
         end else begin
            phase_in = adv_ph;
         end
      end
      if (do_fail) begin
         emit     = 1'b1;
         phase_in = eof ? PH_VER : PH_DISCARD;
      end

      rsp_data_in.status       = rsp_kind_in ? npdu_pkg::ST_OK : fail_st;
      rsp_data_in.control_bits = control_in;
      rsp_data_in.dest_network = dnet_in;
      rsp_data_in.dest_length  = dlen_in;
      rsp_data_in.dest_address = daddr_in;
      rsp_data_in.src_network  = snet_in;
      rsp_data_in.src_length   = slen_in;
      rsp_data_in.src_address  = saddr_in;
      rsp_data_in.hops_left    = hop_in;
      rsp_data_in.data_byte    = rsp_kind_in ? b : version_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_VER;
         addr_cnt_ff  <= '0;
         version_ff   <= 8'd0;
         control_ff   <= 8'd0;
         dnet_ff      <= 16'd0;
         dlen_ff      <= 3'd0;
         daddr_ff     <= '0;
         snet_ff      <= 16'd0;
         slen_ff      <= 3'd0;
         saddr_ff     <= '0;
         hop_ff       <= 8'hFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            phase_ff     <= phase_in;
            addr_cnt_ff  <= addr_cnt_in;
            version_ff   <= version_in;
            control_ff   <= control_in;
            dnet_ff      <= dnet_in;
            dlen_ff      <= dlen_in;
            daddr_ff     <= daddr_in;
            snet_ff      <= snet_in;
            slen_ff      <= slen_in;
            saddr_ff     <= saddr_in;
            hop_ff       <= hop_in;
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept && emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/core/npdu_header_parser_checker.sv
// Port-level checks for the NPDU header parser, bound into every parser instance.
`timescale 1ns / 1ps

module npdu_header_parser_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [npdu_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   logic [1:0] status;

   assign status = rsp_tdata[npdu_pkg::STATUS_LSB +: 2];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_stall_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   a_open_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

   a_payload_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> status == npdu_pkg::ST_OK)
      else $error("payload result with nonzero status");

   a_netmsg_ctl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && status == npdu_pkg::ST_NETMSG
         |-> rsp_tdata[npdu_pkg::CONTROL_LSB + npdu_pkg::CTL_NETMSG_BIT])
      else $error("network message status without control bit");

endmodule

bind npdu_header_parser npdu_header_parser_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: sim/tb_top.sv
// Self-checking testbench for the NPDU header parser: directed frames, then random frames.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_ADDR = npdu_pkg::MAX_ADDR_BYTES_DEF;

   typedef enum logic [3:0] {
      PH_VER, PH_CTRL, PH_DNET_HI, PH_DNET_LO, PH_DLEN, PH_DADR, PH_SNET_HI,
      PH_SNET_LO, PH_SLEN, PH_SADR, PH_HOP, PH_PAYLOAD, PH_DISCARD, PH_DONE
   } parse_phase_type;

   typedef struct packed {
      logic                   kind;
      logic                   last;
      npdu_pkg::rsp_data_type d;
   } hdr_result_type;

   typedef struct packed {
      logic [7:0]     octet;
      logic           eof;
      logic           typed;
      hdr_result_type want;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;
   logic                            req_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [npdu_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            rsp_tlast;

   parse_phase_type phase_q   = PH_VER;
   logic [2:0]      addr_left = '0;
   logic [7:0]      ver_q     = '0;
   logic [7:0]      ctl_q     = '0;
   logic [15:0]     dnet_q    = '0;
   logic [2:0]      dlen_q    = '0;
   logic [55:0]     daddr_q   = '0;
   logic [15:0]     snet_q    = '0;
   logic [2:0]      slen_q    = '0;
   logic [55:0]     saddr_q   = '0;
   logic [7:0]      hops_q    = 8'hFF;

   hdr_result_type pending_records[$];
   int             mismatch_count = 0;
   int             bytes_sent     = 0;
   bit             calm           = 1'b0;
   bit             hold_go        = 1'b0;
   logic [7:0]     frame_q[$];

   string field_names [12] = '{"kind", "last", "status", "control_bits", "dest_network",
                               "dest_length", "dest_address", "src_network", "src_length",
                               "src_address", "hops_left", "data_byte"};

   npdu_header_parser #(.MAX_ADDR_BYTES(MAX_ADDR)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic hdr_result_type make_record(logic kind, npdu_pkg::status_type st,
                                                  logic [7:0] data, logic last);
      hdr_result_type r;
      r.kind           = kind;
      r.last           = last;
      r.d.status       = st;
      r.d.control_bits = ctl_q;
      r.d.dest_network = dnet_q;
      r.d.dest_length  = dlen_q;
      r.d.dest_address = daddr_q;
      r.d.src_network  = snet_q;
      r.d.src_length   = slen_q;
      r.d.src_address  = saddr_q;
      r.d.hops_left    = hops_q;
      r.d.data_byte    = data;
      return r;
   endfunction

   function automatic hdr_result_type blank_header(npdu_pkg::status_type st, logic [7:0] ctl,
                                                   logic [15:0] dnet, logic [7:0] ver,
                                                   logic last);
      hdr_result_type r;
      r                = '0;
      r.last           = last;
      r.d.status       = st;
      r.d.control_bits = ctl;
      r.d.dest_network = dnet;
      r.d.hops_left    = 8'hFF;
      r.d.data_byte    = ver;
      return r;
   endfunction

   function automatic logic [63:0] field_value(hdr_result_type r, int idx);
      case (idx)
         0:       return 64'(r.kind);
         1:       return 64'(r.last);
         2:       return 64'(r.d.status);
         3:       return 64'(r.d.control_bits);
         4:       return 64'(r.d.dest_network);
         5:       return 64'(r.d.dest_length);
         6:       return 64'(r.d.dest_address);
         7:       return 64'(r.d.src_network);
         8:       return 64'(r.d.src_length);
         9:       return 64'(r.d.src_address);
         10:      return 64'(r.d.hops_left);
         default: return 64'(r.d.data_byte);
      endcase
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic eof, output logic got,
                             output hdr_result_type rec);
      logic                 err;
      logic                 passthru;
      npdu_pkg::status_type err_st;
      parse_phase_type      nxt;
      parse_phase_type      after_dest;
      parse_phase_type      after_src;
      got        = 1'b0;
      rec        = '0;
      err        = 1'b0;
      passthru   = 1'b0;
      err_st     = npdu_pkg::ST_OK;
      nxt        = PH_DONE;
      after_dest = ctl_q[npdu_pkg::CTL_SRC_BIT] ? PH_SNET_HI : PH_HOP;
      after_src  = ctl_q[npdu_pkg::CTL_DEST_BIT] ? PH_HOP : PH_DONE;
      case (phase_q)
         PH_CTRL: begin
            ctl_q = b;
            if (b[npdu_pkg::CTL_NETMSG_BIT]) begin
               err    = 1'b1;
               err_st = npdu_pkg::ST_NETMSG;
            end else begin
               nxt = b[npdu_pkg::CTL_DEST_BIT] ? PH_DNET_HI :
                     (b[npdu_pkg::CTL_SRC_BIT] ? PH_SNET_HI : PH_DONE);
            end
         end
         PH_DNET_HI: begin
            dnet_q = {b, 8'h00};
            nxt    = PH_DNET_LO;
         end
         PH_DNET_LO: begin
            dnet_q[7:0] = b;
            nxt         = PH_DLEN;
         end
         PH_DLEN: begin
            if (b > MAX_ADDR) begin
               err    = 1'b1;
               err_st = npdu_pkg::ST_ADDR_LEN;
            end else begin
               dlen_q    = b[2:0];
               addr_left = b[2:0];
               nxt       = (b != 0) ? PH_DADR : after_dest;
            end
         end
         PH_DADR: begin
            daddr_q = {daddr_q[47:0], b};
            if (addr_left != 0) addr_left--;
            nxt = (addr_left != 0) ? PH_DADR : after_dest;
         end
         PH_SNET_HI: begin
            snet_q = {b, 8'h00};
            nxt    = PH_SNET_LO;
         end
         PH_SNET_LO: begin
            snet_q[7:0] = b;
            nxt         = PH_SLEN;
         end
         PH_SLEN: begin
            if (b > MAX_ADDR) begin
               err    = 1'b1;
               err_st = npdu_pkg::ST_ADDR_LEN;
            end else begin
               slen_q    = b[2:0];
               addr_left = b[2:0];
               nxt       = (b != 0) ? PH_SADR : after_src;
            end
         end
         PH_SADR: begin
            saddr_q = {saddr_q[47:0], b};
            if (addr_left != 0) addr_left--;
            nxt = (addr_left != 0) ? PH_SADR : after_src;
         end
         PH_HOP: begin
            hops_q = b;
            nxt    = PH_DONE;
         end
         PH_PAYLOAD: begin
            passthru = 1'b1;
            got      = 1'b1;
            rec      = make_record(1'b1, npdu_pkg::ST_OK, b, eof);
            if (eof) phase_q = PH_VER;
         end
         PH_DISCARD: begin
            passthru = 1'b1;
            if (eof) phase_q = PH_VER;
         end
         default: begin
            addr_left = '0;
            ctl_q     = '0;
            dnet_q    = '0;
            dlen_q    = '0;
            daddr_q   = '0;
            snet_q    = '0;
            slen_q    = '0;
            saddr_q   = '0;
            hops_q    = 8'hFF;
            ver_q     = b;
            nxt       = PH_CTRL;
         end
      endcase
      if (!passthru) begin
         if (err || (eof && nxt != PH_DONE)) begin
            got     = 1'b1;
            rec     = make_record(1'b0, err ? err_st : npdu_pkg::ST_TRUNC, ver_q, eof);
            phase_q = eof ? PH_VER : PH_DISCARD;
         end else if (nxt == PH_DONE) begin
            got     = 1'b1;
            rec     = make_record(1'b0, npdu_pkg::ST_OK, ver_q, eof);
            phase_q = eof ? PH_VER : PH_PAYLOAD;
         end else begin
            phase_q = nxt;
         end
      end
   endtask

   task automatic drive_byte(input logic [7:0] octet, input logic eof, input logic typed,
                             input hdr_result_type want);
      logic           got;
      hdr_result_type rec;
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= octet;
      req_tlast  <= eof;
      do @(posedge clock); while (!req_tready);
      parse_byte(octet, eof, got, rec);
      if (got) pending_records.push_back(typed ? want : rec);
      bytes_sent++;
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (60) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= 36);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      hdr_result_type act;
      hdr_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act.kind = rsp_tuser;
         act.last = rsp_tlast;
         act.d    = npdu_pkg::rsp_data_type'(rsp_tdata);
         if (pending_records.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got kind %0h data %0h",
                     $time, act.kind, act.d.data_byte);
            mismatch_count++;
         end else begin
            want = pending_records.pop_front();
            for (int f = 0; f < 12; f++) begin
               if (field_value(want, f) !== field_value(act, f)) begin
                  $display("%0t ns: %s mismatch, expected %0h, got %0h", $time,
                           field_names[f], field_value(want, f), field_value(act, f));
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      #200000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      stim_row_type dir_rows[$];
      int           mode;
      int           alen;
      int           cut;
      int           frame_no;
      logic [7:0]   ctl;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // truncated right after the version byte
      dir_rows.push_back('{8'h01, 1'b1, 1'b1,
                           blank_header(npdu_pkg::ST_TRUNC, 8'h00, 16'h0, 8'h01, 1'b1)});
      // network message mid-frame, then drop the rest
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'hFF, 1'b0, 1'b1,
                           blank_header(npdu_pkg::ST_NETMSG, 8'hFF, 16'h0, 8'h00, 1'b0)});
      dir_rows.push_back('{8'h55, 1'b1, 1'b0, hdr_result_type'('0)});
      // header fills the frame exactly
      dir_rows.push_back('{8'hFF, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h00, 1'b1, 1'b1,
                           blank_header(npdu_pkg::ST_OK, 8'h00, 16'h0, 8'hFF, 1'b1)});
      // destination length too large on the final byte
      dir_rows.push_back('{8'h01, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h20, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'hFF, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'hFF, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h08, 1'b1, 1'b1,
                           blank_header(npdu_pkg::ST_ADDR_LEN, 8'h20, 16'hFFFF, 8'h01, 1'b1)});
      // empty destination, two-byte source, hop count, payload
      dir_rows.push_back('{8'h01, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h28, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h12, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h34, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h02, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'hAB, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'hCD, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h00, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'hFF, 1'b0, 1'b0, hdr_result_type'('0)});
      dir_rows.push_back('{8'h00, 1'b1, 1'b0, hdr_result_type'('0)});

      foreach (dir_rows[r]) drive_byte(dir_rows[r].octet, dir_rows[r].eof, dir_rows[r].typed,
                                       dir_rows[r].want);

      frame_no = 0;
      while (bytes_sent < 1475) begin
         calm = (frame_no >= 60 && frame_no < 90);
         if (frame_no == 40) hold_go = 1'b1;
         if (frame_no == 20 || frame_no == 100) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_records.size() != 0);
         end

         frame_q.delete();
         mode = $urandom_range(0, 99);
         if (mode < 8) begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
         end else begin
            ctl = 8'($urandom);
            if (mode < 92) ctl[npdu_pkg::CTL_NETMSG_BIT] = 1'b0;
            frame_q.push_back(8'($urandom));
            frame_q.push_back(ctl);
            for (int side = 0; side < 2; side++) begin
               if (ctl[side ? npdu_pkg::CTL_SRC_BIT : npdu_pkg::CTL_DEST_BIT]) begin
                  frame_q.push_back(8'($urandom));
                  frame_q.push_back(8'($urandom));
                  alen = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_ADDR + 1, 255)
                                                      : $urandom_range(0, MAX_ADDR);
                  frame_q.push_back(8'(alen));
                  if (alen <= MAX_ADDR) repeat (alen) frame_q.push_back(8'($urandom));
               end
            end
            if (ctl[npdu_pkg::CTL_DEST_BIT]) frame_q.push_back(8'($urandom));
            repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
            if (mode >= 80 && mode < 92) begin
               cut = $urandom_range(1, frame_q.size() - 1);
               while (frame_q.size() > cut) void'(frame_q.pop_back());
            end
         end

         for (int i = 0; i < frame_q.size(); i++)
            drive_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, hdr_result_type'('0));
         frame_no++;
      end

      calm = 1'b0;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_records.size() != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
